// File: design/erv_pkg.sv
// ----------------------------------------------------------------------------
// erv_pkg
// Shared types, constants and the sine/cosine table for the Euler rotator.
// ----------------------------------------------------------------------------
package erv_pkg;

    // angle units: 1/64 degree
    localparam int FULL_TURN = 23040;
    localparam int QUARTER   = 5760;
    localparam int EIGHTH    = 2880;
    localparam int BIAS_TURN = 69120;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] RAD_K   = 64'd292818;

    localparam int TW = 12;  // offset width, covers 0..EIGHTH

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [15:0] angle_about_x;
        logic signed [15:0] angle_about_y;
        logic signed [15:0] angle_about_z;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
    } out_req_t;

    // classified angle: quadrant, fold flag and table offset
    typedef struct packed {
        logic [1:0]    quad;
        logic          fold;
        logic [TW-1:0] t;
    } ang_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        ang_t               ax;
        ang_t               ay;
        ang_t               az;
    } job_t;

    // table entry: {sin[30:0], cos[30:0]} in Q1.30, both non-negative
    typedef logic [61:0] sc_entry_t;
    typedef sc_entry_t sc_rom_t [0:EIGHTH];

    // taylor evaluation of sine and cosine for every offset, at elaboration
    function automatic sc_rom_t build_sc_rom();
        sc_rom_t     rom;
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] sv;
        for (int i = 0; i <= EIGHTH; i++) begin
            r  = 64'(i) * RAD_K;
            r2 = (r * r) >> 30;
            ts = Q30_ONE - r2 / 72;
            ts = Q30_ONE - ((r2 * ts) >> 30) / 42;
            ts = Q30_ONE - ((r2 * ts) >> 30) / 20;
            ts = Q30_ONE - ((r2 * ts) >> 30) / 6;
            sv = (r * ts) >> 30;
            tc = Q30_ONE - r2 / 90;
            tc = Q30_ONE - ((r2 * tc) >> 30) / 56;
            tc = Q30_ONE - ((r2 * tc) >> 30) / 30;
            tc = Q30_ONE - ((r2 * tc) >> 30) / 12;
            tc = Q30_ONE - ((r2 * tc) >> 30) / 2;
            rom[i] = {sv[30:0], tc[30:0]};
        end
        return rom;
    endfunction

    // shift right by 30 rounding half up, saturate to 32 bits
    function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = (v + 64'sd536870912) >>> 30;
        if (w > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (w < -64'sd2147483648)
            return 32'sh80000000;
        else
            return w[31:0];
    endfunction

endpackage

// File: design/erv_front.sv
// ----------------------------------------------------------------------------
// erv_front
// Reduces the three angles modulo a full turn and splits each into a
// quadrant, a fold flag and a table offset.
// ----------------------------------------------------------------------------
module erv_front
    import erv_pkg::*;
(
    input  in_req_t req,
    output job_t    job
);

    // reduce one angle and classify it
    function automatic ang_t classify(input logic signed [15:0] a);
        logic [16:0] b;
        logic [16:0] m;
        logic [16:0] u;
        ang_t        res;
        b = 17'(BIAS_TURN) + 17'($unsigned(32'(a)));
        if (b >= 17'(4 * FULL_TURN))
            m = b - 17'(4 * FULL_TURN);
        else if (b >= 17'(3 * FULL_TURN))
            m = b - 17'(3 * FULL_TURN);
        else if (b >= 17'(2 * FULL_TURN))
            m = b - 17'(2 * FULL_TURN);
        else
            m = b - 17'(FULL_TURN);
        if (m >= 17'(3 * QUARTER))
        begin
            res.quad = 2'd3;
            u = m - 17'(3 * QUARTER);
        end
        else if (m >= 17'(2 * QUARTER))
        begin
            res.quad = 2'd2;
            u = m - 17'(2 * QUARTER);
        end
        else if (m >= 17'(QUARTER))
        begin
            res.quad = 2'd1;
            u = m - 17'(QUARTER);
        end
        else
        begin
            res.quad = 2'd0;
            u = m;
        end
        res.fold = (u > 17'(EIGHTH));
        res.t    = res.fold ? TW'(17'(QUARTER) - u) : TW'(u);
        return res;
    endfunction

    // vector passes through, angles get classified
    always_comb
    begin
        job.x  = req.vec_x;
        job.y  = req.vec_y;
        job.z  = req.vec_z;
        job.ax = classify(req.angle_about_x);
        job.ay = classify(req.angle_about_y);
        job.az = classify(req.angle_about_z);
    end

endmodule

// File: design/erv_queue.sv
// ----------------------------------------------------------------------------
// erv_queue
// Small queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module erv_queue
    import erv_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wr_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t rd_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    assign full   = (cnt_reg == CW'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_job = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_job;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("push without pop did not grow count");

endmodule

// File: design/erv_rom.sv
// ----------------------------------------------------------------------------
// erv_rom
// Sine/cosine table for offsets up to an eighth turn, registered read.
// ----------------------------------------------------------------------------
module erv_rom
    import erv_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [TW-1:0] addr,
    output sc_entry_t     data
);

    localparam sc_rom_t SC_ROM = build_sc_rom();

    sc_entry_t data_reg;

    assign data = data_reg;

    // registered table read
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= SC_ROM[addr];
    end

endmodule

// File: design/erv_back.sv
// ----------------------------------------------------------------------------
// erv_back
// Table lookup, sign fix-up and the three rotation steps, pipelined.
// ----------------------------------------------------------------------------
module erv_back
    import erv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     empty,
    input  job_t     job,
    output logic     pop,
    output logic     dst_valid,
    input  logic     dst_ready,
    output out_req_t dst_req
);

    typedef logic signed [31:0] s32_t;
    typedef logic signed [63:0] s64_t;

    logic      en;
    logic [6:0] vld_reg;
    logic       out_vld_reg;
    sc_entry_t rom_x;
    sc_entry_t rom_y;
    sc_entry_t rom_z;

    // stage 0 carry
    s32_t x0_reg, y0_reg, z0_reg;
    logic [1:0] qx0_reg, qy0_reg, qz0_reg;
    logic fx0_reg, fy0_reg, fz0_reg;
    // stage 1: signed sine/cosine
    s32_t x1_reg, y1v_reg, z1v_reg;
    s32_t sx_reg, cx_reg, sy1_reg, cy1_reg, sz1_reg, cz1_reg;
    // stage 2: x products
    s64_t p_ycx_reg, p_zsx_reg, p_zcx_reg, p_ysx_reg;
    s32_t x2c_reg, sy2_reg, cy2_reg, sz2_reg, cz2_reg;
    // stage 3: x sums
    s32_t yr_reg, zr_reg, x3c_reg, sy3_reg, cy3_reg, sz3_reg, cz3_reg;
    // stage 4: y products
    s64_t p_xcy_reg, p_zsy_reg, p_zcy_reg, p_xsy_reg;
    s32_t y4c_reg, sz4_reg, cz4_reg;
    // stage 5: y sums
    s32_t xs_reg, zs_reg, y5c_reg, sz5_reg, cz5_reg;
    // stage 6: z products
    s64_t p_xcz_reg, p_ysz_reg, p_xsz_reg, p_ycz_reg;
    s32_t z6c_reg;
    out_req_t out_reg;

    // whole pipeline advances unless the output is held
    assign en        = !out_vld_reg || dst_ready;
    assign pop       = en && !empty;
    assign dst_valid = out_vld_reg;
    assign dst_req   = out_reg;

    erv_rom u_rom_x (.clk(clk), .en(pop), .addr(job.ax.t), .data(rom_x));
    erv_rom u_rom_y (.clk(clk), .en(pop), .addr(job.ay.t), .data(rom_y));
    erv_rom u_rom_z (.clk(clk), .en(pop), .addr(job.az.t), .data(rom_z));

    // quadrant swap and negate of a table entry
    function automatic logic [63:0] fix_sc(input sc_entry_t e, input logic fold,
                                           input logic [1:0] quad);
        s32_t s;
        s32_t c;
        s32_t so;
        s32_t co;
        s = fold ? s32_t'({1'b0, e[30:0]})  : s32_t'({1'b0, e[61:31]});
        c = fold ? s32_t'({1'b0, e[61:31]}) : s32_t'({1'b0, e[30:0]});
        unique case (quad)
            2'd0:    begin so = s;  co = c;  end
            2'd1:    begin so = c;  co = -s; end
            2'd2:    begin so = -s; co = -c; end
            default: begin so = -c; co = s;  end
        endcase
        return {so, co};
    endfunction

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[5:0], !empty};
            out_vld_reg <= vld_reg[6];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 0
            x0_reg  <= job.x;
            y0_reg  <= job.y;
            z0_reg  <= job.z;
            qx0_reg <= job.ax.quad;
            qy0_reg <= job.ay.quad;
            qz0_reg <= job.az.quad;
            fx0_reg <= job.ax.fold;
            fy0_reg <= job.ay.fold;
            fz0_reg <= job.az.fold;
            // stage 1
            x1_reg  <= x0_reg;
            y1v_reg <= y0_reg;
            z1v_reg <= z0_reg;
            {sx_reg, cx_reg}   <= fix_sc(rom_x, fx0_reg, qx0_reg);
            {sy1_reg, cy1_reg} <= fix_sc(rom_y, fy0_reg, qy0_reg);
            {sz1_reg, cz1_reg} <= fix_sc(rom_z, fz0_reg, qz0_reg);
            // stage 2
            p_ycx_reg <= y1v_reg * cx_reg;
            p_zsx_reg <= z1v_reg * sx_reg;
            p_zcx_reg <= z1v_reg * cx_reg;
            p_ysx_reg <= y1v_reg * sx_reg;
            x2c_reg <= x1_reg;
            sy2_reg <= sy1_reg;
            cy2_reg <= cy1_reg;
            sz2_reg <= sz1_reg;
            cz2_reg <= cz1_reg;
            // stage 3
            yr_reg  <= rnd_sat(p_ycx_reg + p_zsx_reg);
            zr_reg  <= rnd_sat(p_zcx_reg - p_ysx_reg);
            x3c_reg <= x2c_reg;
            sy3_reg <= sy2_reg;
            cy3_reg <= cy2_reg;
            sz3_reg <= sz2_reg;
            cz3_reg <= cz2_reg;
            // stage 4
            p_xcy_reg <= x3c_reg * cy3_reg;
            p_zsy_reg <= zr_reg * sy3_reg;
            p_zcy_reg <= zr_reg * cy3_reg;
            p_xsy_reg <= x3c_reg * sy3_reg;
            y4c_reg <= yr_reg;
            sz4_reg <= sz3_reg;
            cz4_reg <= cz3_reg;
            // stage 5
            xs_reg  <= rnd_sat(p_xcy_reg + p_zsy_reg);
            zs_reg  <= rnd_sat(p_zcy_reg - p_xsy_reg);
            y5c_reg <= y4c_reg;
            sz5_reg <= sz4_reg;
            cz5_reg <= cz4_reg;
            // stage 6
            p_xcz_reg <= xs_reg * cz5_reg;
            p_ysz_reg <= y5c_reg * sz5_reg;
            p_xsz_reg <= xs_reg * sz5_reg;
            p_ycz_reg <= y5c_reg * cz5_reg;
            z6c_reg   <= zs_reg;
            // output register
            out_reg.rot_x <= rnd_sat(p_xcz_reg - p_ysz_reg);
            out_reg.rot_y <= rnd_sat(p_xsz_reg + p_ycz_reg);
            out_reg.rot_z <= z6c_reg;
        end
    end

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg) && $stable(out_vld_reg))
        else $error("pipeline moved while output stalled");

    a_pop_feeds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> vld_reg[0])
        else $error("popped job not captured");

    a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !dst_ready) |-> !pop)
        else $error("pop during output stall");

endmodule

// File: design/euler_rotate_vector_3d_core.sv
// ----------------------------------------------------------------------------
// euler_rotate_vector_3d_core
// Rotates a Q16.16 vector about X, then Y, then Z by angles in Q10.6 degrees.
// ----------------------------------------------------------------------------
// Usage:
//   src channel (src_valid/src_ready/src_req) takes one request per cycle:
//   the vector and three angles. dst channel (dst_valid/dst_ready/dst_req)
//   returns one rotated, saturated vector per request, in order.
//   Throughput is one request per cycle, set by the fully pipelined back
//   end (table read, sign fix-up, three multiply/sum pairs with four
//   32x32 multipliers each), whenever dst_ready does not stall the output.
//   The front classifies angles and writes a QUEUE_DEPTH entry queue;
//   src_ready drops only when that queue is full.
//   When dst_ready is low the back pipeline holds; the queue keeps taking
//   requests until full.
//   Reset clears the queue and all valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module euler_rotate_vector_3d_core
    import erv_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_ready,
    input  in_req_t  src_req,
    output logic     dst_valid,
    input  logic     dst_ready,
    output out_req_t dst_req
);

    job_t front_job;
    job_t head_job;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic q_push;

    assign src_ready = !q_full;
    assign q_push    = src_valid && !q_full;

    erv_front u_front (
        .req (src_req),
        .job (front_job)
    );

    erv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_job (front_job),
        .full   (q_full),
        .pop    (q_pop),
        .empty  (q_empty),
        .rd_job (head_job)
    );

    erv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .job       (head_job),
        .pop       (q_pop),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_req   (dst_req)
    );

endmodule

// File: dv/tb_euler_rotate_vector_3d_core.sv
// ----------------------------------------------------------------------------
// tb_euler_rotate_vector_3d_core
// Streams vectors and angle triples through the Euler rotator, predicts each
// rotated vector with a fixed-point sine/cosine and rotation model, and
// compares every result in order under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_euler_rotate_vector_3d_core;
    import erv_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     src_valid;
    logic     src_ready;
    in_req_t  src_req;
    logic     dst_valid;
    logic     dst_ready;
    out_req_t dst_req;

    out_req_t rotated_q[$];
    int       err_cnt;
    int       gap_left;
    int       burst_left;
    int       stall_mode;

    euler_rotate_vector_3d_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_req   (src_req),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_req   (dst_req)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // taylor sine and cosine of an offset in [0, 2880], q2.30
    function automatic void taylor_sc(input logic [63:0] t,
                                      output logic signed [63:0] s,
                                      output logic signed [63:0] c);
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] ts;
        logic [63:0] tc;
        begin
            r  = t * 64'd292818;
            r2 = (r * r) >> 30;
            ts = (64'd1 << 30) - r2 / 72;
            ts = (64'd1 << 30) - ((r2 * ts) >> 30) / 42;
            ts = (64'd1 << 30) - ((r2 * ts) >> 30) / 20;
            ts = (64'd1 << 30) - ((r2 * ts) >> 30) / 6;
            s  = $signed((r * ts) >> 30);
            tc = (64'd1 << 30) - r2 / 90;
            tc = (64'd1 << 30) - ((r2 * tc) >> 30) / 56;
            tc = (64'd1 << 30) - ((r2 * tc) >> 30) / 30;
            tc = (64'd1 << 30) - ((r2 * tc) >> 30) / 12;
            tc = (64'd1 << 30) - ((r2 * tc) >> 30) / 2;
            c  = $signed(tc);
        end
    endfunction

    // angle in 1/64 degree to sine and cosine with quadrant folding
    function automatic void angle_sc(input logic signed [15:0] a,
                                     output logic signed [63:0] sn,
                                     output logic signed [63:0] cs);
        int          m;
        int          q;
        int          u;
        logic signed [63:0] s;
        logic signed [63:0] c;
        begin
            m = int'(a) % 23040;
            if (m < 0)
                m += 23040;
            q = m / 5760;
            u = m % 5760;
            if (u <= 2880)
                taylor_sc(64'(u), s, c);
            else
                taylor_sc(64'(5760 - u), c, s);
            case (q)
                0: begin sn = s;  cs = c;  end
                1: begin sn = c;  cs = -s; end
                2: begin sn = -s; cs = -c; end
                default: begin sn = -c; cs = s; end
            endcase
        end
    endfunction

    // shift by 30 rounding toward plus infinity at half, then clamp
    function automatic logic signed [63:0] round_clamp(input logic signed [127:0] v);
        logic signed [127:0] w;
        begin
            w = (v + 128'sd536870912) >>> 30;
            if (w > 128'sd2147483647)
                w = 128'sd2147483647;
            else if (w < -128'sd2147483648)
                w = -128'sd2147483648;
            return 64'(w);
        end
    endfunction

    function automatic out_req_t rotate_xyz(input in_req_t r);
        logic signed [63:0] sx, cx, sy, cy, sz, cz;
        logic signed [63:0] x, y, z, y1, z1, x2, z2, x3, y3;
        out_req_t o;
        begin
            angle_sc(r.angle_about_x, sx, cx);
            angle_sc(r.angle_about_y, sy, cy);
            angle_sc(r.angle_about_z, sz, cz);
            x  = 64'(r.vec_x);
            y  = 64'(r.vec_y);
            z  = 64'(r.vec_z);
            y1 = round_clamp(128'(y) * 128'(cx) + 128'(z) * 128'(sx));
            z1 = round_clamp(128'(z) * 128'(cx) - 128'(y) * 128'(sx));
            x2 = round_clamp(128'(x) * 128'(cy) + 128'(z1) * 128'(sy));
            z2 = round_clamp(128'(z1) * 128'(cy) - 128'(x) * 128'(sy));
            x3 = round_clamp(128'(x2) * 128'(cz) - 128'(y1) * 128'(sz));
            y3 = round_clamp(128'(x2) * 128'(sz) + 128'(y1) * 128'(cz));
            o.rot_x = x3[31:0];
            o.rot_y = y3[31:0];
            o.rot_z = z2[31:0];
            return o;
        end
    endfunction

    // send one request, bursts with random gaps
    task automatic send_request(input in_req_t r);
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 20);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            while (gap_left > 0)
            begin
                src_valid <= 1'b0;
                @(posedge clk);
                gap_left--;
            end
            burst_left--;
            src_valid <= 1'b1;
            src_req   <= r;
            rotated_q.push_back(rotate_xyz(r));
            @(posedge clk);
            while (!src_ready)
                @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 7) * 2880 - 11520);
            1: return 16'($urandom_range(0, 23040) - 11520);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic in_req_t make_req(input logic signed [31:0] x,
        input logic signed [31:0] y, input logic signed [31:0] z,
        input logic signed [15:0] ax, input logic signed [15:0] ay,
        input logic signed [15:0] az);
        in_req_t r;
        begin
            r.vec_x = x; r.vec_y = y; r.vec_z = z;
            r.angle_about_x = ax; r.angle_about_y = ay; r.angle_about_z = az;
            return r;
        end
    endfunction

    // extremes, octant and quadrant boundaries, saturation
    task automatic test_directed();
        begin
            send_request(make_req(32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0, 0));
            send_request(make_req(32'sh00010000, 0, 0, 0, 0, 5760));
            send_request(make_req(0, 32'sh00010000, 0, 5760, 0, 0));
            send_request(make_req(0, 0, 32'sh00010000, 0, 5760, 0));
            send_request(make_req(32'sh00010000, 32'sh00010000, 32'sh00010000,
                                  2880, 2881, 2879));
            send_request(make_req(32'sh00010000, -32'sh00010000, 32'sh00010000,
                                  11520, 17280, 23040));
            send_request(make_req(32'sh00010000, 32'sh00010000, 32'sh00010000,
                                  -5760, -2880, -23040));
            send_request(make_req(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                  2880, 2880, 2880));
            send_request(make_req(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                  2880, 2880, 2880));
            send_request(make_req(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                  16'sh7fff, 16'sh8000, 16'sh7fff));
            send_request(make_req(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                  16'sh8000, 16'sh7fff, 16'sh8000));
            send_request(make_req(-1, -1, -1, 1, -1, 1));
            send_request(make_req(32'sh00008000, 32'sh00008000, -32'sh00008000,
                                  8640, 14400, 20160));
            send_request(make_req(32'sh12345678, 32'shedcba987, 32'sh0f0f0f0f,
                                  16'sh5555, 16'shaaaa, 16'sh0ff0));
        end
    endtask

    task automatic test_random();
        begin
            for (int i = 0; i < 550; i++)
                send_request(make_req(rand_word(), rand_word(), rand_word(),
                                      rand_angle(), rand_angle(), rand_angle()));
        end
    endtask

    // sink stalls: phases of always-ready, light and heavy stalling
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_ready  <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 99) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: dst_ready <= 1'b1;
                1: dst_ready <= ($urandom_range(0, 3) != 0);
                default: dst_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        out_req_t exp_r;
        if (rst_n && dst_valid && dst_ready)
        begin
            if (rotated_q.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, dst_req);
                err_cnt++;
            end
            else
            begin
                exp_r = rotated_q.pop_front();
                if (dst_req.rot_x !== exp_r.rot_x)
                begin
                    $display("%0t rot_x expected %h actual %h", $time, exp_r.rot_x,
                             dst_req.rot_x);
                    err_cnt++;
                end
                if (dst_req.rot_y !== exp_r.rot_y)
                begin
                    $display("%0t rot_y expected %h actual %h", $time, exp_r.rot_y,
                             dst_req.rot_y);
                    err_cnt++;
                end
                if (dst_req.rot_z !== exp_r.rot_z)
                begin
                    $display("%0t rot_z expected %h actual %h", $time, exp_r.rot_z,
                             dst_req.rot_z);
                    err_cnt++;
                end
            end
        end
    end

    // timeout
    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        err_cnt    = 0;
        burst_left = 0;
        gap_left   = 0;
        rst_n      = 1'b0;
        src_valid  = 1'b0;
        src_req    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        src_valid <= 1'b0;
        while (rotated_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
